[design/itda_pkg.sv]
// shared types, constants and elaboration functions for the decimal text formatter
`timescale 1ns / 1ps
`default_nettype none
package itda_pkg;

	localparam int WORD_BITS_DEF = 32;
	localparam int TAB_BITS = 68;
	localparam int MAX_POW = 20;

	localparam logic [7:0] ASCII_ZERO = 8'd48;
	localparam logic [7:0] ASCII_MINUS = 8'd45;

	typedef struct packed {
		logic load;
		logic sign_step;
		logic digit_step;
	} itda_cmd_t;

	typedef struct packed {
		logic neg_in;
		logic emit;
		logic pos_last;
		logic slot_free;
	} itda_stat_t;

	function automatic logic [TAB_BITS-1:0] pow10(input int p);
		logic [TAB_BITS-1:0] r;
		r = TAB_BITS'(1);
		for (int i = 0; i < MAX_POW; i++) begin
			if (i < p) begin
				r = TAB_BITS'(r * TAB_BITS'(10));
			end
		end
		return r;
	endfunction

	// decimal digits needed for the largest unsigned word of the given width
	function automatic int num_digits(input int bits);
		logic [TAB_BITS-1:0] lim;
		int n;
		lim = TAB_BITS'(1) << bits;
		n = 0;
		for (int p = 0; p <= MAX_POW; p++) begin
			if (pow10(p) < lim) begin
				n = n + 1;
			end
		end
		return n;
	endfunction

endpackage
`default_nettype wire

[design/itda_dp.sv]
// datapath: magnitude register, digit extraction by power-of-ten compare, output register
`timescale 1ns / 1ps
`default_nettype none
module itda_dp #(
	parameter int WORD_BITS = itda_pkg::WORD_BITS_DEF
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_we,
	input  wire logic                 cfg_wdata,
	input  wire logic [WORD_BITS-1:0] value,
	input  wire itda_pkg::itda_cmd_t  cmd,
	output itda_pkg::itda_stat_t      stat,
	output logic                      out_valid,
	input  wire logic                 out_ready,
	output logic [7:0]                text_byte,
	output logic                      last_byte
);
	import itda_pkg::*;

	localparam int NDIG = num_digits(WORD_BITS);
	localparam int PW = $clog2(NDIG);
	localparam int XW = WORD_BITS + 4;

	logic                 unsigned_mode_q;
	logic [WORD_BITS-1:0] rem_q;
	logic [PW-1:0]        pos_q;
	logic                 started_q;
	logic                 out_valid_q;
	logic [7:0]           text_q;
	logic                 last_q;

	logic [XW-1:0]        mult_tab [NDIG][9];
	logic [XW-1:0]        row [9];
	logic [XW-1:0]        rem_x;
	logic [XW-1:0]        sub;
	logic [3:0]           digit;
	logic                 neg_in;

	// multiples 1..9 of each power of ten
	for (genvar gp = 0; gp < NDIG; gp++) begin : g_pow
		for (genvar gd = 1; gd <= 9; gd++) begin : g_mul
			localparam logic [TAB_BITS-1:0] M = TAB_BITS'(TAB_BITS'(gd) * pow10(gp));
			assign mult_tab[gp][gd-1] = M[XW-1:0];
		end
	end

	assign row = mult_tab[pos_q];
	assign rem_x = {4'b0, rem_q};

	always_comb begin
		digit = '0;
		sub = '0;
		for (int d = 1; d <= 9; d++) begin
			if (rem_x >= row[d-1]) begin
				digit = 4'(d);
				sub = row[d-1];
			end
		end
	end

	assign neg_in = !unsigned_mode_q && value[WORD_BITS-1];

	assign stat.neg_in = neg_in;
	assign stat.emit = (digit != 4'd0) || started_q || (pos_q == '0);
	assign stat.pos_last = (pos_q == '0);
	assign stat.slot_free = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			unsigned_mode_q <= 1'b0;
			out_valid_q <= 1'b0;
			started_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				unsigned_mode_q <= cfg_wdata;
			end
			if (cmd.load) begin
				started_q <= 1'b0;
			end else if (cmd.digit_step && digit != 4'd0) begin
				started_q <= 1'b1;
			end
			if (cmd.sign_step || (cmd.digit_step && stat.emit)) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			rem_q <= neg_in ? (~value + WORD_BITS'(1)) : value;
			pos_q <= PW'(NDIG - 1);
		end else if (cmd.digit_step) begin
			rem_q <= rem_q - sub[WORD_BITS-1:0];
			pos_q <= pos_q - PW'(1);
		end
		if (cmd.sign_step) begin
			text_q <= ASCII_MINUS;
			last_q <= 1'b0;
		end else if (cmd.digit_step && stat.emit) begin
			text_q <= ASCII_ZERO + {4'b0, digit};
			last_q <= stat.pos_last;
		end
	end

	assign out_valid = out_valid_q;
	assign text_byte = text_q;
	assign last_byte = last_q;

endmodule
`default_nettype wire

[design/itda_ctrl.sv]
// controller: sequences load, sign and digit steps of one word
`timescale 1ns / 1ps
`default_nettype none
module itda_ctrl (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	output logic                      in_ready,
	input  wire itda_pkg::itda_stat_t stat,
	output itda_pkg::itda_cmd_t       cmd
);
	import itda_pkg::*;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SIGN,
		ST_DIGIT
	} state_t;

	state_t state_q;
	logic   in_ready_q;

	always_comb begin
		cmd.load = (state_q == ST_IDLE) && in_valid;
		cmd.sign_step = (state_q == ST_SIGN) && stat.slot_free;
		cmd.digit_step = (state_q == ST_DIGIT) && (stat.slot_free || !stat.emit);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			in_ready_q <= 1'b1;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						state_q <= stat.neg_in ? ST_SIGN : ST_DIGIT;
						in_ready_q <= 1'b0;
					end
				end
				ST_SIGN: begin
					if (stat.slot_free) begin
						state_q <= ST_DIGIT;
					end
				end
				ST_DIGIT: begin
					if (cmd.digit_step && stat.pos_last) begin
						state_q <= ST_IDLE;
						in_ready_q <= 1'b1;
					end
				end
				default: begin
					state_q <= ST_IDLE;
					in_ready_q <= 1'b1;
				end
			endcase
		end
	end

	assign in_ready = in_ready_q;

endmodule
`default_nettype wire

[design/integer_to_decimal_ascii_top.sv]
// top level of the decimal text formatter: controller, datapath and checks
// the input transfer loads the word, then one digit position per cycle, most significant first,
// over all positions of the widest word (10 for 32 bits), stalled only while a character waits
// for the output register; a minus sign for a negative signed word takes a step of its own first
// the next word is taken once the last character sits in the output register
// reset clears the mode register to signed, the controller to idle and the output to empty
`timescale 1ns / 1ps
`default_nettype none
module integer_to_decimal_ascii_top #(
	parameter int WORD_BITS = itda_pkg::WORD_BITS_DEF
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_we,
	input  wire logic                 cfg_wdata,
	input  wire logic                 in_valid,
	output logic                      in_ready,
	input  wire logic [WORD_BITS-1:0] value,
	output logic                      out_valid,
	input  wire logic                 out_ready,
	output logic [7:0]                text_byte,
	output logic                      last_byte
);
	import itda_pkg::*;

	itda_cmd_t  cmd;
	itda_stat_t stat;

	itda_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	itda_dp #(
		.WORD_BITS (WORD_BITS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.value     (value),
		.cmd       (cmd),
		.stat      (stat),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.text_byte (text_byte),
		.last_byte (last_byte)
	);

	a_busy_after_in: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("input taken while a word is in progress");

	a_char_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (text_byte == ASCII_MINUS ||
			(text_byte >= ASCII_ZERO && text_byte <= ASCII_ZERO + 8'd9)))
		else $error("output character out of range");

	a_sign_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && text_byte == ASCII_MINUS) |-> !last_byte)
		else $error("minus sign marked as last");

	a_mid_word_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !last_byte) |-> !in_ready)
		else $error("controller idle before the word is finished");

endmodule
`default_nettype wire
